### hdl/tobs_pkg.sv
// Shared types, constants and helper functions for the TCP option byte serializer.
package tobs_pkg;

    localparam int unsigned OPT_ALIGN      = 4;
    localparam int unsigned OPT_MAX_BYTES  = 20;
    localparam int unsigned BUF_W          = OPT_MAX_BYTES * 8;
    localparam int unsigned LEN_W          = 5;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] KIND_EOL    = 8'd0;
    localparam logic [7:0] KIND_NOOP   = 8'd1;
    localparam logic [7:0] KIND_MSS    = 8'd2;
    localparam logic [7:0] KIND_WSCALE = 8'd3;
    localparam logic [7:0] KIND_TSTAMP = 8'd8;
    localparam logic [7:0] LEN_MSS     = 8'd4;
    localparam logic [7:0] LEN_WSCALE  = 8'd3;
    localparam logic [7:0] LEN_TSTAMP  = 8'd10;

    // One fully built option block: byte 0 in the lowest bits.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [BUF_W-1:0] bytes;
    } t_desc;

    // Puts a 32-bit word into wire order, most significant byte lowest.
    function automatic logic [31:0] be32_bytes(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

### hdl/tobs_front.sv
// Front end: classifies a request and lays out its padded option bytes.
module tobs_front (
    input  logic                 i_has_mss,
    input  logic [15:0]          i_mss_value,
    input  logic                 i_has_wscale,
    input  logic [3:0]           i_wscale_shift,
    input  logic                 i_has_tstamp,
    input  logic [31:0]          i_ts_value,
    input  logic [31:0]          i_ts_echo,
    output tobs_pkg::t_desc      o_desc,
    output logic                 o_empty
);

    logic [31:0]                     seg_m;
    logic [23:0]                     seg_w;
    logic [79:0]                     seg_t;
    logic [2:0]                      w_off;
    logic [2:0]                      t_off;
    logic [tobs_pkg::LEN_W-1:0]      raw_len;
    logic [tobs_pkg::LEN_W-1:0]      raw_p3;
    logic [tobs_pkg::LEN_W-1:0]      tot_len;
    logic [tobs_pkg::BUF_W-1:0]      opt_bytes;
    logic [tobs_pkg::BUF_W-1:0]      padded;

    assign seg_m = {i_mss_value[7:0], i_mss_value[15:8], tobs_pkg::LEN_MSS, tobs_pkg::KIND_MSS};
    assign seg_w = {4'b0000, i_wscale_shift, tobs_pkg::LEN_WSCALE, tobs_pkg::KIND_WSCALE};
    assign seg_t = {tobs_pkg::be32_bytes(i_ts_echo), tobs_pkg::be32_bytes(i_ts_value),
                    tobs_pkg::LEN_TSTAMP, tobs_pkg::KIND_TSTAMP};

    // Byte offsets of the window scale and timestamp options.
    assign w_off = i_has_mss ? 3'd4 : 3'd0;
    assign t_off = w_off + (i_has_wscale ? 3'd3 : 3'd0);

    assign raw_len = (i_has_mss    ? 5'd4  : 5'd0)
                   + (i_has_wscale ? 5'd3  : 5'd0)
                   + (i_has_tstamp ? 5'd10 : 5'd0);
    assign raw_p3  = raw_len + 5'd3;
    assign tot_len = {raw_p3[tobs_pkg::LEN_W-1:2], 2'b00};

    always_comb begin
        opt_bytes = '0;
        if (i_has_mss) begin
            opt_bytes = opt_bytes | {{(tobs_pkg::BUF_W-32){1'b0}}, seg_m};
        end
        if (i_has_wscale) begin
            opt_bytes = opt_bytes | ({{(tobs_pkg::BUF_W-24){1'b0}}, seg_w} << {w_off, 3'b000});
        end
        if (i_has_tstamp) begin
            opt_bytes = opt_bytes | ({{(tobs_pkg::BUF_W-80){1'b0}}, seg_t} << {t_off, 3'b000});
        end
    end

    // The byte just past the options stays zero (end of list); the rest of
    // the partial word is filled with no-op bytes.
    always_comb begin
        padded = opt_bytes;
        for (int i = 0; i < tobs_pkg::OPT_MAX_BYTES; i++) begin
            if (5'(i) > raw_len && 5'(i) < tot_len) begin
                padded[i*8 +: 8] = tobs_pkg::KIND_NOOP;
            end
        end
    end

    assign o_desc.bytes = padded;
    assign o_desc.len   = tot_len;
    assign o_empty      = (raw_len == '0);

endmodule

### hdl/tobs_fifo.sv
// Short descriptor queue between the front end and the byte serializer.
module tobs_fifo #(
    parameter int unsigned DEPTH = tobs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tobs_pkg::t_desc i_wdata,
    output logic            o_full,
    input  logic            i_pop,
    output tobs_pkg::t_desc o_rdata,
    output logic            o_nempty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tobs_pkg::t_desc   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    assign o_full   = (r_cnt == CNT_W'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_rdata  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

### hdl/tobs_back.sv
// Back end: an output register shifts an option block out, a byte per cycle if ready.
module tobs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tobs_pkg::t_desc               i_desc,
    input  logic                          i_desc_valid,
    output logic                          o_desc_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_byte,
    output logic                          o_last,
    output logic [tobs_pkg::LEN_W-1:0]    o_total
);

    logic [tobs_pkg::BUF_W-1:0]  r_buf, n_buf;
    logic [tobs_pkg::LEN_W-1:0]  r_rem, n_rem;
    logic [tobs_pkg::LEN_W-1:0]  r_len, n_len;
    logic                        r_valid, n_valid;
    logic                        adv;
    logic                        more;

    assign adv  = !r_valid || i_ready;
    assign more = r_valid && (r_rem != 5'd1);

    always_comb begin
        n_buf      = r_buf;
        n_rem      = r_rem;
        n_len      = r_len;
        n_valid    = r_valid;
        o_desc_pop = 1'b0;
        if (adv) begin
            if (more) begin
                n_buf = {8'h00, r_buf[tobs_pkg::BUF_W-1:8]};
                n_rem = r_rem - 1'b1;
            end else if (i_desc_valid) begin
                n_buf      = i_desc.bytes;
                n_rem      = i_desc.len;
                n_len      = i_desc.len;
                n_valid    = 1'b1;
                o_desc_pop = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rem   <= '0;
        end else begin
            r_valid <= n_valid;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        r_len <= n_len;
    end

    assign o_valid = r_valid;
    assign o_byte  = r_buf[7:0];
    assign o_last  = (r_rem == 5'd1);
    assign o_total = r_len;

endmodule

### hdl/tcp_option_byte_serializer.sv
// A request's bytes are held in the descriptor queue, then loaded into the output register.
// Throughput: one option byte per cycle on the output while the byte side is ready; a request
// of N padded bytes (4 to 20) holds the single output byte register until its last byte is taken.
// Requests are taken one per cycle while the descriptor queue has room; empty ones are dropped.
// Reset is synchronous and active low; it empties the queue and the output register.
// Top level of the TCP option byte serializer.
module tcp_option_byte_serializer #(
    parameter int unsigned QUEUE_DEPTH = tobs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request side.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata from bit 0: mss_value[15:0], wscale_shift[19:16], ts_value[51:20],
    // ts_echo[83:52], zero fill [87:84].
    input  logic [87:0] i_s_tdata,
    // tuser from bit 0: has_mss, has_wscale, has_tstamp.
    input  logic [2:0]  i_s_tuser,
    // Byte side.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata from bit 0: out_byte[7:0], total_length[12:8], zero fill [15:13].
    output logic [15:0] o_m_tdata,
    // tlast carries is_last: high on the final byte of a request's options.
    output logic        o_m_tlast
);

    tobs_pkg::t_desc             front_desc;
    tobs_pkg::t_desc             queue_desc;
    logic                        front_empty;
    logic                        q_full;
    logic                        q_nempty;
    logic                        q_push;
    logic                        q_pop;
    logic [7:0]                  out_byte;
    logic [tobs_pkg::LEN_W-1:0]  out_total;

    // The front end is pure logic; the queue's free slot is the request
    // side's ready, so a new word is taken while earlier bytes still drain.
    tobs_front u_front (
        .i_has_mss      (i_s_tuser[0]),
        .i_mss_value    (i_s_tdata[15:0]),
        .i_has_wscale   (i_s_tuser[1]),
        .i_wscale_shift (i_s_tdata[19:16]),
        .i_has_tstamp   (i_s_tuser[2]),
        .i_ts_value     (i_s_tdata[51:20]),
        .i_ts_echo      (i_s_tdata[83:52]),
        .o_desc         (front_desc),
        .o_empty        (front_empty)
    );

    assign o_s_tready = !q_full;
    // A request with no option produces no bytes and never enters the queue.
    assign q_push     = i_s_tvalid && !q_full && !front_empty;

    tobs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_wdata  (front_desc),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_rdata  (queue_desc),
        .o_nempty (q_nempty)
    );

    // The serializer loads the next block in the same cycle that the last
    // byte of the previous one is taken, so blocks follow without a gap.
    tobs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (queue_desc),
        .i_desc_valid (q_nempty),
        .o_desc_pop   (q_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (out_byte),
        .o_last       (o_m_tlast),
        .o_total      (out_total)
    );

    assign o_m_tdata = {3'b000, out_total, out_byte};

endmodule

### hdl/tobs_checker.sv
// Port-level checker for the TCP option byte serializer, bound to the top level.
module tobs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [87:0] i_s_tdata,
    input logic [2:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast
);

    // A request word that is not taken stays offered and unchanged.
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready
            |=> i_s_tvalid && $stable(i_s_tdata) && $stable(i_s_tuser))
        else $error("request word changed while waiting");

    // A stalled byte word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("byte word changed while stalled");

    // The padded length is a whole number of four-byte words, four to twenty.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[9:8] == 2'b00 && o_m_tdata[12:8] != 5'd0
                       && o_m_tdata[12:8] <= 5'd20)
        else $error("total length out of range");

    // Within a block the next byte follows at once and keeps the same length.
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast
            |=> o_m_tvalid && o_m_tdata[12:8] == $past(o_m_tdata[12:8]))
        else $error("block interrupted or length changed mid-block");

    // Reset empties the output register.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind tcp_option_byte_serializer tobs_checker u_tobs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

### dv/tobs_byte_checker.sv
// Checker for the TCP option byte serializer: predicts the option bytes of each request and compares.
module tobs_byte_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // tdata from bit 0: mss_value, wscale_shift, ts_value, ts_echo, zero fill.
    input  logic [87:0] i_s_tdata,
    // tuser from bit 0: has_mss, has_wscale, has_tstamp.
    input  logic [2:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // tdata from bit 0: out_byte, total_length, zero fill.
    input  logic [15:0] i_m_tdata,
    input  logic        i_m_tlast,
    output int          o_fail_count = 0,
    output int          o_pending = 0
);

    typedef struct packed {
        logic [7:0]                 opt_byte;
        logic                       last;
        logic [tobs_pkg::LEN_W-1:0] total;
    } t_opt_byte;

    t_opt_byte pending_bytes[$];
    int        fails = 0;

    // Builds the wire image of one request and queues every byte of it.
    task automatic queue_option_bytes(input logic [2:0] flags, input logic [87:0] data);
        logic [7:0]  wire_b [tobs_pkg::OPT_MAX_BYTES];
        int          n;
        logic [15:0] mss;
        logic [3:0]  shift;
        logic [31:0] tsv;
        logic [31:0] tse;
        t_opt_byte   e;
        mss   = data[15:0];
        shift = data[19:16];
        tsv   = data[51:20];
        tse   = data[83:52];
        n     = 0;
        if (flags[0]) begin
            wire_b[0] = tobs_pkg::KIND_MSS;
            wire_b[1] = tobs_pkg::LEN_MSS;
            wire_b[2] = mss[15:8];
            wire_b[3] = mss[7:0];
            n = 4;
        end
        if (flags[1]) begin
            wire_b[n]     = tobs_pkg::KIND_WSCALE;
            wire_b[n + 1] = tobs_pkg::LEN_WSCALE;
            wire_b[n + 2] = {4'h0, shift};
            n = n + 3;
        end
        if (flags[2]) begin
            wire_b[n]     = tobs_pkg::KIND_TSTAMP;
            wire_b[n + 1] = tobs_pkg::LEN_TSTAMP;
            for (int k = 0; k < 4; k++) begin
                wire_b[n + 2 + k] = tsv[31 - 8 * k -: 8];
                wire_b[n + 6 + k] = tse[31 - 8 * k -: 8];
            end
            n = n + 10;
        end
        // A partial last word gets one end-of-list byte, then no-ops to the boundary.
        if (n % tobs_pkg::OPT_ALIGN != 0) begin
            wire_b[n] = tobs_pkg::KIND_EOL;
            n = n + 1;
            while (n % tobs_pkg::OPT_ALIGN != 0) begin
                wire_b[n] = tobs_pkg::KIND_NOOP;
                n = n + 1;
            end
        end
        for (int k = 0; k < n; k++) begin
            e.opt_byte = wire_b[k];
            e.last     = (k == n - 1);
            e.total    = tobs_pkg::LEN_W'(n);
            pending_bytes.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        t_opt_byte exp_b;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                queue_option_bytes(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (pending_bytes.size() == 0) begin
                    $error("option byte 0x%02h arrived with no byte outstanding",
                           i_m_tdata[7:0]);
                    fails++;
                end else begin
                    exp_b = pending_bytes.pop_front();
                    if (i_m_tdata[7:0] !== exp_b.opt_byte) begin
                        $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                               exp_b.opt_byte, i_m_tdata[7:0]);
                        fails++;
                    end
                    if (i_m_tlast !== exp_b.last) begin
                        $error("is_last mismatch: expected %0d, actual %0d",
                               exp_b.last, i_m_tlast);
                        fails++;
                    end
                    if (i_m_tdata[12:8] !== exp_b.total) begin
                        $error("total_length mismatch: expected %0d, actual %0d",
                               exp_b.total, i_m_tdata[12:8]);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= pending_bytes.size();
        o_fail_count <= fails;
    end

endmodule

### dv/tb.sv
// Testbench top for the TCP option byte serializer: request stimulus, idling phases and verdict.
module tb;

    // The run is stopped here if the bytes stop flowing; far above the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;
    // Random requests per idling phase; empty requests come on top of this.
    localparam int RAND_PER_PHASE = 66;
    // Cycles allowed after the last expected byte for anything stray to show up.
    localparam int DRAIN_CYCLES = 24;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        logic [2:0]  flags;     // has_mss, has_wscale, has_tstamp from bit 0
        logic [15:0] mss;
        logic [3:0]  shift;
        logic [31:0] tsv;
        logic [31:0] tse;
    } t_opt_req;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    t_idle_mode  idle_mode = IDLE_NONE;

    tcp_option_byte_serializer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    tobs_byte_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The byte side stalls at random in the receiver phases, 45 percent of the time alone
    // and 11 percent when the sender idles as well.
    always @(posedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: m_tready <= ($urandom_range(99) >= 45);
            IDLE_BOTH:     m_tready <= ($urandom_range(99) >= 11);
            default:       m_tready <= 1'b1;
        endcase
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_opt_req mk_req(input logic [2:0] flags, input logic [15:0] mss,
                                        input logic [3:0] shift, input logic [31:0] tsv,
                                        input logic [31:0] tse);
        t_opt_req r;
        r.flags = flags;
        r.mss   = mss;
        r.shift = shift;
        r.tsv   = tsv;
        r.tse   = tse;
        return r;
    endfunction

    // Offers one request word and returns at the edge where it is taken. Any idle gap
    // is placed before the word, so tvalid is changed at most once per edge.
    task automatic send_request(input t_opt_req r);
        int gap;
        int idle_pct;
        gap = 0;
        idle_pct = (idle_mode == IDLE_SENDER) ? 45 : (idle_mode == IDLE_BOTH) ? 11 : 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, r.tse, r.tsv, r.shift, r.mss};
        s_tuser  <= r.flags;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Holds the request side quiet until every predicted byte has been seen. The first
    // edge lets the checker count a request taken at the current edge.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_opt_req r;
        int       counted;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 4; p++) begin
            // Changing the mode first lets the drain below carry it into effect.
            idle_mode <= t_idle_mode'(p);
            wait_drained();

            if (p == 0) begin
                // Directed words: every option alone and in each combination, the field
                // extremes, and the padding cases of one, two and three filler bytes.
                send_request(mk_req(3'b000, 16'h1234, 4'h5, 32'h0, 32'h0));
                send_request(mk_req(3'b000, 16'hFFFF, 4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF));
                send_request(mk_req(3'b001, 16'h0000, 4'h0, 32'h0, 32'h0));
                send_request(mk_req(3'b001, 16'hFFFF, 4'h0, 32'h0, 32'h0));
                send_request(mk_req(3'b001, 16'h00FF, 4'h0, 32'h0, 32'h0));
                send_request(mk_req(3'b001, 16'hFF00, 4'h0, 32'h0, 32'h0));
                send_request(mk_req(3'b010, 16'h0, 4'h0, 32'h0, 32'h0));
                send_request(mk_req(3'b010, 16'h0, 4'hE, 32'h0, 32'h0));
                // Shift above fourteen is passed through untouched.
                send_request(mk_req(3'b010, 16'h0, 4'hF, 32'h0, 32'h0));
                send_request(mk_req(3'b100, 16'h0, 4'h0, 32'h00000000, 32'h00000000));
                send_request(mk_req(3'b100, 16'h0, 4'h0, 32'hFFFFFFFF, 32'hFFFFFFFF));
                send_request(mk_req(3'b100, 16'h0, 4'h0, 32'hA5A5A5A5, 32'h5A5A5A5A));
                send_request(mk_req(3'b100, 16'h0, 4'h0, 32'h01234567, 32'h89ABCDEF));
                send_request(mk_req(3'b011, 16'h8000, 4'h1, 32'h0, 32'h0));
                send_request(mk_req(3'b101, 16'h0001, 4'h0, 32'h80000000, 32'h00000001));
                send_request(mk_req(3'b110, 16'h0, 4'h7, 32'hDEADBEEF, 32'hCAFEF00D));
                send_request(mk_req(3'b111, 16'h05B4, 4'h7, 32'h12345678, 32'h9ABCDEF0));
                send_request(mk_req(3'b111, 16'hFFFF, 4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF));
                send_request(mk_req(3'b111, 16'h0000, 4'h0, 32'h00000000, 32'h00000000));
                send_request(mk_req(3'b111, 16'h5555, 4'hA, 32'h55555555, 32'hAAAAAAAA));
                // Pause until the directed bytes are all out, then let the random part in.
                wait_drained();
            end

            counted = 0;
            while (counted < RAND_PER_PHASE) begin
                // About one request in twelve selects nothing and must vanish.
                r.flags = ($urandom_range(11) == 0) ? 3'b000 : 3'($urandom_range(7, 1));
                case ($urandom_range(7))
                    0:       r.mss = 16'h0000;
                    1:       r.mss = 16'hFFFF;
                    default: r.mss = 16'($urandom);
                endcase
                r.shift = 4'($urandom_range(15));
                r.tsv   = ($urandom_range(7) == 0) ? {32{1'($urandom)}} : $urandom;
                r.tse   = ($urandom_range(7) == 0) ? {32{1'($urandom)}} : $urandom;
                send_request(r);
                if (r.flags != 3'b000)
                    counted++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### tcp_option_byte_serializer.f
hdl/tobs_pkg.sv
hdl/tobs_front.sv
hdl/tobs_fifo.sv
hdl/tobs_back.sv
hdl/tcp_option_byte_serializer.sv
hdl/tobs_checker.sv
dv/tobs_byte_checker.sv
dv/tb.sv
